// File: rtl/core/utcal_pkg.sv
// ----------------------------------------------------------------------------
// utcal_pkg
// Constants for the seconds-to-UTC-calendar converter: fixed divisors,
// reciprocals for division by constants, and the March-based month table.
// ----------------------------------------------------------------------------
`default_nettype none

package utcal_pkg;

  // time unit divisors
  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
  localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;

  // seconds / 86400 is done as (seconds >> 7) / 675
  localparam int unsigned DAY_PRE_SH = 7;
  localparam int unsigned DAY_SH     = 36;
  localparam int unsigned DAY_RCP_W  = 27;
  localparam logic [DAY_RCP_W-1:0] DAY_RCP =
    DAY_RCP_W'(((64'd1 << DAY_SH) + 64'd674) / 64'd675);

  // reciprocal for the hour split
  localparam int unsigned HOUR_SH    = 29;
  localparam int unsigned HOUR_RCP_W = 18;
  localparam logic [HOUR_RCP_W-1:0] HOUR_RCP =
    HOUR_RCP_W'(((64'd1 << HOUR_SH) + 64'd3599) / 64'd3600);

  // reciprocal for the minute split
  localparam int unsigned MIN_SH    = 18;
  localparam int unsigned MIN_RCP_W = 13;
  localparam logic [MIN_RCP_W-1:0] MIN_RCP =
    MIN_RCP_W'(((64'd1 << MIN_SH) + 64'd59) / 64'd60);

  // reciprocal for the weekday split
  localparam int unsigned WK_SH    = 20;
  localparam int unsigned WK_RCP_W = 18;
  localparam logic [WK_RCP_W-1:0] WK_RCP =
    WK_RCP_W'(((64'd1 << WK_SH) + 64'd6) / 64'd7);

  // reciprocal for the four-year cycle split
  localparam int unsigned CYC_SH    = 28;
  localparam int unsigned CYC_RCP_W = 18;
  localparam logic [CYC_RCP_W-1:0] CYC_RCP =
    CYC_RCP_W'(((64'd1 << CYC_SH) + 64'd1460) / 64'd1461);

  // 1970-01-01 was a Thursday
  localparam logic [2:0] WDAY_OFS = 3'd4;

  // day index counted from 1968-03-01 on a plain four-year leap pattern
  localparam logic [9:0]  EPOCH_OFS  = 10'd671;    // 1968-03-01 .. 1970-01-01
  localparam logic [15:0] SKIP_DAY   = 16'd47541;  // 2100-03-01, days since epoch
  localparam logic [10:0] DAYS_4Y    = 11'd1461;
  localparam logic [8:0]  DAYS_YEAR  = 9'd365;
  localparam logic [5:0]  NOLEAP_CYC = 6'd33;      // cycle that starts in 2100

  // March-based month starts, March is entry zero
  localparam logic [8:0] MONTH_START [12] = '{
    9'd0,   9'd31,  9'd61,  9'd92,  9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };
  localparam logic [3:0] MP_JAN   = 4'd10;  // first month of the next year
  localparam logic [3:0] MP_SHIFT = 4'd2;   // March-based to January-based
  localparam logic [8:0] MAR_YDAY = 9'd59;  // day of year of March 1, common year
  localparam logic [8:0] JAN_BACK = 9'd306; // March..December length
  localparam logic [7:0] YEAR_BASE = 8'd68; // 1968 minus 1900

endpackage

`default_nettype wire

// File: rtl/core/epoch_seconds_to_utc_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_calendar
// Converts an unsigned count of seconds since 1970-01-01 00:00 UTC into the
// broken-down UTC calendar time through an eight-stage pipeline.
// ----------------------------------------------------------------------------
//   channel | direction | handshake                 | payload
//   in      | input     | in_valid_i / in_ready_o   | epoch_seconds_i
//   out     | output    | out_valid_o / out_ready_i | second_of_minute_o .. day_of_year_o
//
// One word enters per clock unless out_ready_i stalls the pipeline; each result passes
// through s1_q to s8_q, a depth set by the chain of reciprocal multiplies and remainders.
// Each stage holds its word while the next stage is full and stalled, so
// bubbles close up and a stall drops or repeats nothing.
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_utc_calendar #(
  parameter int unsigned SECONDS_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] epoch_seconds_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [5:0]       second_of_minute_o,
  output logic [5:0]       minute_of_hour_o,
  output logic [4:0]       hour_of_day_o,
  output logic [4:0]       day_of_month_o,
  output logic [3:0]       month_index_o,
  output logic [7:0]       years_since_1900_o,
  output logic [2:0]       weekday_o,
  output logic [8:0]       day_of_year_o
);

  import utcal_pkg::*;

  localparam int unsigned TW    = (SECONDS_BITS < 32) ? SECONDS_BITS : 32;
  localparam int unsigned DAY_W = TW - 16;
  localparam int unsigned JW    = DAY_W + 1;
  localparam int unsigned XW    = TW - DAY_PRE_SH;
  localparam int unsigned P1W   = XW + DAY_RCP_W;
  localparam int unsigned PWKW  = JW + WK_RCP_W;
  localparam int unsigned PCYW  = JW + CYC_RCP_W;
  localparam int unsigned PHW   = 17 + HOUR_RCP_W;
  localparam int unsigned PMW   = 12 + MIN_RCP_W;
  localparam int unsigned NST   = 8;

  typedef struct packed {
    logic [TW-1:0]    t;
    logic [DAY_W-1:0] day;
  } s1_t;

  typedef struct packed {
    logic [16:0]   rem;
    logic [JW-1:0] jd;
    logic [JW-1:0] wx;
    logic [JW-1:0] wq;
  } s2_t;

  typedef struct packed {
    logic [16:0]   rem;
    logic [4:0]    hour;
    logic [JW-1:0] jd;
    logic [5:0]    cyc;
    logic [2:0]    wday;
  } s3_t;

  typedef struct packed {
    logic [11:0] remh;
    logic [4:0]  hour;
    logic [10:0] r;
    logic [5:0]  cyc;
    logic [2:0]  wday;
  } s4_t;

  typedef struct packed {
    logic [11:0] remh;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [10:0] r;
    logic [1:0]  yc;
    logic [5:0]  cyc;
    logic [2:0]  wday;
  } s5_t;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [8:0] doy;
    logic [1:0] yc;
    logic [5:0] cyc;
    logic [2:0] wday;
  } s6_t;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [8:0] doy;
    logic [3:0] mp;
    logic [1:0] yc;
    logic [5:0] cyc;
    logic [2:0] wday;
  } s7_t;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [4:0] mday;
    logic [3:0] mon;
    logic [7:0] year;
    logic [2:0] wday;
    logic [8:0] yday;
  } s8_t;

  logic [NST-1:0] valid_q;
  logic [NST-1:0] en;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  s5_t s5_d, s5_q;
  s6_t s6_d, s6_q;
  s7_t s7_d, s7_q;
  s8_t s8_d, s8_q;

  logic [TW-1:0]   t_in;
  logic [P1W-1:0]  day_prod;
  logic [PWKW-1:0] wk_prod;
  logic [PCYW-1:0] cyc_prod;
  logic [PHW-1:0]  hour_prod;
  logic [PMW-1:0]  min_prod;
  logic [JW-1:0]   wx;
  logic [2:0]      yc_ge;
  logic [10:0]     mp_ge;
  logic            leap;
  logic            jan_feb;

  // stage enables: a stage moves when it is empty or its successor moves
  always_comb begin
    en[NST-1] = !valid_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NST-1];

  // valid bits travel with the words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // stage 1: whole days by reciprocal multiply
  always_comb begin
    t_in       = epoch_seconds_i[TW-1:0];
    day_prod   = P1W'(t_in[TW-1:DAY_PRE_SH]) * P1W'(DAY_RCP);
    s1_d.t     = t_in;
    s1_d.day   = DAY_W'(day_prod >> DAY_SH);
  end

  // stage 2: seconds of day, leap-cycle day index, weekday quotient
  always_comb begin
    wx       = JW'(s1_q.day) + JW'(WDAY_OFS);
    wk_prod  = PWKW'(wx) * PWKW'(WK_RCP);
    s2_d.rem = 17'(s1_q.t - (TW'(s1_q.day) * TW'(SECS_PER_DAY)));
    // skip the missing 2100-02-29 so the plain four-year pattern holds
    s2_d.jd  = JW'(s1_q.day) + JW'(EPOCH_OFS)
             + JW'(JW'(s1_q.day) >= JW'(SKIP_DAY));
    s2_d.wx  = wx;
    s2_d.wq  = JW'(wk_prod >> WK_SH);
  end

  // stage 3: hour quotient, four-year cycle quotient, weekday remainder
  always_comb begin
    hour_prod = PHW'(s2_q.rem) * PHW'(HOUR_RCP);
    cyc_prod  = PCYW'(s2_q.jd) * PCYW'(CYC_RCP);
    s3_d.rem  = s2_q.rem;
    s3_d.hour = 5'(hour_prod >> HOUR_SH);
    s3_d.jd   = s2_q.jd;
    s3_d.cyc  = 6'(cyc_prod >> CYC_SH);
    s3_d.wday = 3'(s2_q.wx - (s2_q.wq * JW'(DAYS_PER_WEEK)));
  end

  // stage 4: seconds of hour, day within the cycle
  always_comb begin
    s4_d.remh = 12'(s3_q.rem - (17'(s3_q.hour) * 17'(SECS_PER_HOUR)));
    s4_d.hour = s3_q.hour;
    s4_d.r    = 11'(s3_q.jd - (JW'(s3_q.cyc) * JW'(DAYS_4Y)));
    s4_d.cyc  = s3_q.cyc;
    s4_d.wday = s3_q.wday;
  end

  // stage 5: minute quotient, year within the cycle
  always_comb begin
    min_prod = PMW'(s4_q.remh) * PMW'(MIN_RCP);
    for (int k = 0; k < 3; k++) begin
      yc_ge[k] = s4_q.r >= 11'(11'(k + 1) * 11'(DAYS_YEAR));
    end
    s5_d.remh = s4_q.remh;
    s5_d.min  = 6'(min_prod >> MIN_SH);
    s5_d.hour = s4_q.hour;
    s5_d.r    = s4_q.r;
    s5_d.yc   = 2'($countones(yc_ge));
    s5_d.cyc  = s4_q.cyc;
    s5_d.wday = s4_q.wday;
  end

  // stage 6: second remainder, March-based day of year
  always_comb begin
    s6_d.sec  = 6'(s5_q.remh - (12'(s5_q.min) * 12'(SECS_PER_MIN)));
    s6_d.min  = s5_q.min;
    s6_d.hour = s5_q.hour;
    s6_d.doy  = 9'(s5_q.r - (11'(s5_q.yc) * 11'(DAYS_YEAR)));
    s6_d.yc   = s5_q.yc;
    s6_d.cyc  = s5_q.cyc;
    s6_d.wday = s5_q.wday;
  end

  // stage 7: March-based month from the start table
  always_comb begin
    for (int k = 0; k < 11; k++) begin
      mp_ge[k] = s6_q.doy >= MONTH_START[k+1];
    end
    s7_d.sec  = s6_q.sec;
    s7_d.min  = s6_q.min;
    s7_d.hour = s6_q.hour;
    s7_d.doy  = s6_q.doy;
    s7_d.mp   = 4'($countones(mp_ge));
    s7_d.yc   = s6_q.yc;
    s7_d.cyc  = s6_q.cyc;
    s7_d.wday = s6_q.wday;
  end

  // stage 8: calendar fields
  always_comb begin
    jan_feb   = s7_q.mp >= MP_JAN;
    // leap when first year of a cycle, except the cycle that starts in 2100
    leap      = (s7_q.yc == 2'd0) && (s7_q.cyc != NOLEAP_CYC);
    s8_d.sec  = s7_q.sec;
    s8_d.min  = s7_q.min;
    s8_d.hour = s7_q.hour;
    s8_d.mday = 5'(s7_q.doy - MONTH_START[s7_q.mp] + 9'd1);
    s8_d.mon  = jan_feb ? 4'(s7_q.mp - MP_JAN) : 4'(s7_q.mp + MP_SHIFT);
    s8_d.year = YEAR_BASE + (8'(s7_q.cyc) << 2) + 8'(s7_q.yc) + 8'(jan_feb);
    s8_d.wday = s7_q.wday;
    s8_d.yday = jan_feb ? 9'(s7_q.doy - JAN_BACK)
                        : 9'(s7_q.doy + MAR_YDAY + 9'(leap));
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (en[0]) s1_q <= s1_d;
    if (en[1]) s2_q <= s2_d;
    if (en[2]) s3_q <= s3_d;
    if (en[3]) s4_q <= s4_d;
    if (en[4]) s5_q <= s5_d;
    if (en[5]) s6_q <= s6_d;
    if (en[6]) s7_q <= s7_d;
    if (en[7]) s8_q <= s8_d;
  end

  // result word
  assign second_of_minute_o = s8_q.sec;
  assign minute_of_hour_o   = s8_q.min;
  assign hour_of_day_o      = s8_q.hour;
  assign day_of_month_o     = s8_q.mday;
  assign month_index_o      = s8_q.mon;
  assign years_since_1900_o = s8_q.year;
  assign weekday_o          = s8_q.wday;
  assign day_of_year_o      = s8_q.yday;

endmodule

`default_nettype wire
